/* rtl/core/w3f_pkg.sv */
// shared types and constants of the 3x3 window filter
`default_nettype none

package w3f_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int WIN_SIZE    = 9;
  localparam int ROW_W       = 12;
  localparam int WIDTH_REG_W = 11;
  localparam int HEIGHT_W    = 13;
  localparam int MIN_DIM     = 3;
  localparam int MAX_HEIGHT  = 4096;
  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int SUM_W       = 12;
  localparam int LAP_W       = 11;

  // floor(s / 9) == (s * 7282) >> 16 for every nine-sample sum
  localparam logic [12:0] RECIP_NINE  = 13'd7282;
  localparam int          RECIP_SHIFT = 16;

  // window taps, row major
  localparam int WIN_UP     = 1;
  localparam int WIN_LEFT   = 3;
  localparam int WIN_CENTER = 4;
  localparam int WIN_RIGHT  = 5;
  localparam int WIN_DOWN   = 7;

  localparam logic FILTER_BOX     = 1'b0;
  localparam logic FILTER_LAPLACE = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [WIN_SIZE-1:0] window_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_FILTER_MODE  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic room;
    logic nonempty;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

/* rtl/core/w3f_if.sv */
// stream interfaces for pixels in and filtered results out
`default_nettype none

interface w3f_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface w3f_res_if #(
  parameter int COL_W = 10
);
  logic             valid;
  logic             ready;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic [11:0]      out_row;
  logic [COL_W-1:0] out_col;
  logic             last_pixel;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_row, output out_col, output last_pixel, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_row, input out_col, input last_pixel, output ready);
endinterface

`default_nettype wire

/* rtl/core/w3f_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module w3f_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/w3f_front.sv */
// front end: raster counters, line store and window assembly
`default_nettype none

module w3f_front
  import w3f_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  w3f_pix_if.sink                     pixel,
  input  wire logic [WIDTH_REG_W-1:0] image_width,
  input  wire logic [HEIGHT_W-1:0]    image_height,
  input  wire logic                   room,
  output logic                        push,
  output window_t                     win,
  output logic      [ROW_W-1:0]       row_out,
  output logic      [CW-1:0]          col_out,
  output logic                        last_out
);

  localparam int WCMP = (CW + 1 > WIDTH_REG_W) ? CW + 1 : WIDTH_REG_W;

  logic [CW-1:0]      column;
  logic [ROW_W-1:0]   row;
  logic [WCMP-1:0]    width_ext;
  logic [WCMP-1:0]    width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic               last_col;
  logic               last_row;
  logic               emit;
  logic               accept;
  pixel_t             px;

  logic               s1_valid;
  logic               s1_emit;
  logic               s1_last;
  pixel_t             s1_px;
  logic [ROW_W-1:0]   s1_row;
  logic [CW-1:0]      s1_col;
  logic [CW-1:0]      s1_addr;

  logic [2*PIX_W-1:0] ram_rdata;
  pixel_t             top;
  pixel_t             mid;
  pixel_t             c2_top, c2_mid, c2_bot;
  pixel_t             c1_top, c1_mid, c1_bot;

  assign pixel.ready = room;
  assign accept      = pixel.valid && room;
  assign px          = {pixel.in_blue, pixel.in_green, pixel.in_red};

  // clamp the configured image size
  always_comb begin
    width_ext = WCMP'(image_width);
    if (image_width < WIDTH_REG_W'(MIN_DIM)) begin
      width_eff = WCMP'(MIN_DIM);
    end else if (width_ext > WCMP'(MAX_WIDTH)) begin
      width_eff = WCMP'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (image_height < HEIGHT_W'(MIN_DIM)) begin
      height_eff = HEIGHT_W'(MIN_DIM);
    end else if (image_height > HEIGHT_W'(MAX_HEIGHT)) begin
      height_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      height_eff = image_height;
    end
  end

  assign last_col = (WCMP'(column) + WCMP'(1)) >= width_eff;
  assign last_row = (HEIGHT_W'(row) + HEIGHT_W'(1)) >= height_eff;
  assign emit     = (row >= ROW_W'(2)) && (column >= CW'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          column <= '0;
          row    <= last_row ? '0 : row + ROW_W'(1);
        end else begin
          column <= column + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= px;
      s1_emit <= emit;
      s1_last <= last_col && last_row;
      s1_row  <= row - ROW_W'(1);
      s1_col  <= column - CW'(1);
      s1_addr <= column;
    end
  end

  // one word per column: upper row above middle row
  w3f_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata ({ram_rdata[PIX_W-1:0], s1_px}),
    .re    (accept),
    .raddr (column),
    .rdata (ram_rdata)
  );

  assign top = ram_rdata[2*PIX_W-1:PIX_W];
  assign mid = ram_rdata[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      c2_top <= c1_top;
      c2_mid <= c1_mid;
      c2_bot <= c1_bot;
      c1_top <= top;
      c1_mid <= mid;
      c1_bot <= s1_px;
    end
  end

  always_comb begin
    win[0] = c2_top;
    win[1] = c1_top;
    win[2] = top;
    win[3] = c2_mid;
    win[4] = c1_mid;
    win[5] = mid;
    win[6] = c2_bot;
    win[7] = c1_bot;
    win[8] = s1_px;
  end

  assign push     = s1_valid && s1_emit;
  assign row_out  = s1_row;
  assign col_out  = s1_col;
  assign last_out = s1_last;

endmodule

`default_nettype wire

/* rtl/core/w3f_queue.sv */
// short fifo between window assembly and filter arithmetic
`default_nettype none

module w3f_queue
  import w3f_pkg::*;
#(
  parameter int WIDTH = 256,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output queue_status_t         status
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  assign rdata           = slots[rd_ptr];
  // room for one more item besides the one that may still be in flight
  assign status.room     = count <= CNTW'(DEPTH - 2);
  assign status.nonempty = count != '0;
  assign status.full     = count == CNTW'(DEPTH);

endmodule

`default_nettype wire

/* rtl/core/w3f_back.sv */
// back end: box average or laplace per channel, result register
`default_nettype none

module w3f_back
  import w3f_pkg::*;
#(
  parameter int COL_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             filter_mode,
  input  wire window_t          head_win,
  input  wire logic [ROW_W-1:0] head_row,
  input  wire logic [COL_W-1:0] head_col,
  input  wire logic             head_last,
  input  wire logic             head_valid,
  output logic                  pop,
  w3f_res_if.source             result
);

  logic                        b1_valid;
  logic [2:0][SUM_W-1:0]       b1_sum;
  logic [2:0][LAP_W-1:0]       b1_lap;
  logic [ROW_W-1:0]            b1_row;
  logic [COL_W-1:0]            b1_col;
  logic                        b1_last;
  logic                        b1_en;
  logic                        b2_en;

  logic [2:0][SUM_W-1:0]       sum_next;
  logic [2:0][LAP_W-1:0]       lap_next;
  logic [2:0][CH_W-1:0]        px_next;

  assign b2_en = !result.valid || result.ready;
  assign b1_en = !b1_valid || b2_en;
  assign pop   = head_valid && b1_en;

  // stage 1: nine-sample sum and signed laplace per channel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_next[ch] = '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
        sum_next[ch] = sum_next[ch] + SUM_W'(head_win[i][CH_W*ch +: CH_W]);
      end
      lap_next[ch] = {1'b0, head_win[WIN_CENTER][CH_W*ch +: CH_W], 2'b00}
                   - LAP_W'(head_win[WIN_UP][CH_W*ch +: CH_W])
                   - LAP_W'(head_win[WIN_DOWN][CH_W*ch +: CH_W])
                   - LAP_W'(head_win[WIN_LEFT][CH_W*ch +: CH_W])
                   - LAP_W'(head_win[WIN_RIGHT][CH_W*ch +: CH_W]);
    end
  end

  // stage 2: divide by nine through the reciprocal, clamp the laplace
  always_comb begin
    logic [SUM_W+12:0]       prod;
    logic signed [LAP_W-1:0] lap;
    for (int ch = 0; ch < 3; ch++) begin
      prod = b1_sum[ch] * RECIP_NINE;
      lap  = $signed(b1_lap[ch]);
      if (filter_mode == FILTER_LAPLACE) begin
        if (lap < 0) begin
          px_next[ch] = '0;
        end else if (lap > LAP_W'(255)) begin
          px_next[ch] = '1;
        end else begin
          px_next[ch] = lap[CH_W-1:0];
        end
      end else begin
        px_next[ch] = prod[RECIP_SHIFT +: CH_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (b1_en) begin
        b1_valid <= head_valid;
      end
      if (b2_en) begin
        result.valid <= b1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_sum  <= sum_next;
      b1_lap  <= lap_next;
      b1_row  <= head_row;
      b1_col  <= head_col;
      b1_last <= head_last;
    end
    if (b2_en && b1_valid) begin
      result.out_red    <= px_next[0];
      result.out_green  <= px_next[1];
      result.out_blue   <= px_next[2];
      result.out_row    <= b1_row;
      result.out_col    <= b1_col;
      result.last_pixel <= b1_last;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/window_3x3_blur_laplace_filter_top.sv */
// top level of the 3x3 box blur / laplace window filter
// throughput: one pixel per clock while the fifo has room, set by the single-port-pair
//   line store ram; a result is valid once the pixel that completes its window has
//   passed the line store read, fifo write, filter stage and result register
// border pixels produce no result; the last interior pixel of an image flags last_pixel
// reset (synchronous, active high): counters, fifo and valid flags clear, registers take
//   width 640, height 480, box mode; line store contents stay undefined, no clearing pass
`default_nettype none

module window_3x3_blur_laplace_filter_top
  import w3f_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  w3f_pix_if.sink                pixel,
  w3f_res_if.source              result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  // fifo entry: window, row, column, last flag
  localparam int QW = PIX_W * WIN_SIZE + ROW_W + CW + 1;

  // configuration registers
  logic [WIDTH_REG_W-1:0] image_width;
  logic [HEIGHT_W-1:0]    image_height;
  logic                   filter_mode;
  logic                   cfg_write;

  // front to queue
  logic             q_push;
  window_t          f_win;
  logic [ROW_W-1:0] f_row;
  logic [CW-1:0]    f_col;
  logic             f_last;
  logic [QW-1:0]    q_wdata;

  // queue to back
  logic [QW-1:0]    q_rdata;
  logic             q_pop;
  queue_status_t    q_stat;
  window_t          h_win;
  logic [ROW_W-1:0] h_row;
  logic [CW-1:0]    h_col;
  logic             h_last;

  // apb: write completes on the access cycle, no wait states
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_REG_W'(640);
      image_height <= HEIGHT_W'(480);
      filter_mode  <= FILTER_BOX;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_W-1:0];
        REG_FILTER_MODE:  filter_mode  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      REG_FILTER_MODE:  prdata = DATA_W'(filter_mode);
      default:          prdata = '0;
    endcase
  end

  // front: counts raster position, reads and rewrites the line store,
  // shifts the window columns and hands complete interior windows on
  w3f_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .pixel        (pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .room         (q_stat.room),
    .push         (q_push),
    .win          (f_win),
    .row_out      (f_row),
    .col_out      (f_col),
    .last_out     (f_last)
  );

  assign q_wdata = {f_win, f_row, f_col, f_last};

  // decouples the front from output stalls; the front only takes a pixel
  // while there is room for it behind the one still in flight
  w3f_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_stat)
  );

  assign {h_win, h_row, h_col, h_last} = q_rdata;

  // back: filter arithmetic in two stages ending at the result register
  w3f_back #(
    .COL_W (CW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .filter_mode (filter_mode),
    .head_win    (h_win),
    .head_row    (h_row),
    .head_col    (h_col),
    .head_last   (h_last),
    .head_valid  (q_stat.nonempty),
    .pop         (q_pop),
    .result      (result)
  );

  // a window never arrives at a full queue
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("window pushed into full queue");

  // the back end only takes what the queue holds
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_stat.nonempty)
    else $error("queue popped while empty");

  // no result sits in the top row or the left column
  a_interior_result: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.out_row != '0 && result.out_col != '0))
    else $error("result on a border position");

endmodule

`default_nettype wire

/* tb/sv/w3f_result_checker.sv */
// checker that predicts results and register reads from observed transfers and compares them
`timescale 1ns / 1ps

module w3f_result_checker
  import w3f_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  w3f_pix_if                     pixel,
  w3f_res_if                     result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  input  wire logic [DATA_W-1:0] prdata,
  input  wire logic              pready,
  output int unsigned            errors,
  output int unsigned            outstanding
);

  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int CH_MAX       = 2 ** CH_W - 1;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } filtered_pixel_t;

  logic [WIDTH_REG_W-1:0] width_reg;
  logic [HEIGHT_W-1:0]    height_reg;
  logic                   mode_reg;
  pixel_t                 upper_line  [MAX_WIDTH];
  pixel_t                 middle_line [MAX_WIDTH];
  pixel_t                 prev_cols   [6];  // [0..2] column c-2 top..bottom, [3..5] column c-1
  int unsigned            next_col;
  int unsigned            next_row;
  int unsigned            error_total = 0;
  filtered_pixel_t        expected_pixels [$];

  // one colour channel of the window, red in the low byte
  function automatic logic [CH_W-1:0] filter_channel(window_t win, int ch, logic mode);
    int acc;
    acc = 0;
    if (mode == FILTER_LAPLACE) begin
      acc = 4 * int'(win[WIN_CENTER][ch*CH_W +: CH_W])
          - int'(win[WIN_UP][ch*CH_W +: CH_W]) - int'(win[WIN_DOWN][ch*CH_W +: CH_W])
          - int'(win[WIN_LEFT][ch*CH_W +: CH_W]) - int'(win[WIN_RIGHT][ch*CH_W +: CH_W]);
      if (acc < 0) acc = 0;
      if (acc > CH_MAX) acc = CH_MAX;
      return CH_W'(acc);
    end
    for (int i = 0; i < WIN_SIZE; i++) acc += int'(win[i][ch*CH_W +: CH_W]);
    return CH_W'(acc / WIN_SIZE);
  endfunction

  task automatic take_pixel(pixel_t px);
    int unsigned     eff_w;
    int unsigned     eff_h;
    int unsigned     col;
    pixel_t          top_px;
    pixel_t          mid_px;
    window_t         win;
    logic            end_col;
    logic            end_row;
    filtered_pixel_t res;
    eff_w = (width_reg < MIN_DIM) ? MIN_DIM : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    eff_h = (height_reg < MIN_DIM) ? MIN_DIM :
            (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    col    = next_col % MAX_WIDTH;
    top_px = upper_line[col];
    mid_px = middle_line[col];
    win[0] = prev_cols[0]; win[1] = prev_cols[3]; win[2] = top_px;
    win[3] = prev_cols[1]; win[4] = prev_cols[4]; win[5] = mid_px;
    win[6] = prev_cols[2]; win[7] = prev_cols[5]; win[8] = px;
    end_col = (next_col + 1 >= eff_w);
    end_row = (next_row + 1 >= eff_h);
    if (next_row >= 2 && next_col >= 2) begin
      res.red   = filter_channel(win, 0, mode_reg);
      res.green = filter_channel(win, 1, mode_reg);
      res.blue  = filter_channel(win, 2, mode_reg);
      res.row   = ROW_W'(next_row - 1);
      res.col   = COL_W'(next_col - 1);
      res.last  = end_col && end_row;
      expected_pixels.push_back(res);
    end
    prev_cols[0] = prev_cols[3];
    prev_cols[1] = prev_cols[4];
    prev_cols[2] = prev_cols[5];
    prev_cols[3] = top_px;
    prev_cols[4] = mid_px;
    prev_cols[5] = px;
    upper_line[col]  = mid_px;
    middle_line[col] = px;
    if (end_col) begin
      next_col = 0;
      next_row = end_row ? 0 : next_row + 1;
    end else begin
      next_col++;
    end
  endtask

  always @(posedge clk) begin
    filtered_pixel_t   got;
    filtered_pixel_t   want;
    logic [DATA_W-1:0] field;
    logic [DATA_W-1:0] mask;
    if (rst) begin
      width_reg  = WIDTH_REG_W'(RESET_WIDTH);
      height_reg = HEIGHT_W'(RESET_HEIGHT);
      mode_reg   = FILTER_BOX;
      prev_cols  = '{default: '0};
      next_col   = 0;
      next_row   = 0;
      expected_pixels.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_index_t'(paddr[ADDR_W-1:2]))
            REG_IMAGE_WIDTH:  width_reg  = pwdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = pwdata[HEIGHT_W-1:0];
            REG_FILTER_MODE:  mode_reg   = pwdata[0];
            default: ;
          endcase
        end else begin
          field = '0;
          mask  = '0;
          case (reg_index_t'(paddr[ADDR_W-1:2]))
            REG_IMAGE_WIDTH: begin
              field = DATA_W'(width_reg);
              mask  = DATA_W'({WIDTH_REG_W{1'b1}});
            end
            REG_IMAGE_HEIGHT: begin
              field = DATA_W'(height_reg);
              mask  = DATA_W'({HEIGHT_W{1'b1}});
            end
            REG_FILTER_MODE: begin
              field = DATA_W'(mode_reg);
              mask  = DATA_W'(1);
            end
            default: ;
          endcase
          if ((prdata & mask) !== field) begin
            error_total++;
            $display("%0t: register read at 0x%0h expected 0x%0h actual 0x%0h",
                     $time, paddr, field, prdata & mask);
          end
        end
      end

      if (result.valid && result.ready) begin
        got.red   = result.out_red;
        got.green = result.out_green;
        got.blue  = result.out_blue;
        got.row   = result.out_row;
        got.col   = result.out_col;
        got.last  = result.last_pixel;
        if (expected_pixels.size() == 0) begin
          error_total++;
          $display({"%0t: result with none expected, actual r=%0d g=%0d b=%0d ",
                    "row=%0d col=%0d last=%0b"},
                   $time, got.red, got.green, got.blue, got.row, got.col, got.last);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            error_total++;
            $display({"%0t: result mismatch, expected r=%0d g=%0d b=%0d row=%0d col=%0d ",
                      "last=%0b, actual r=%0d g=%0d b=%0d row=%0d col=%0d last=%0b"},
                     $time, want.red, want.green, want.blue, want.row, want.col, want.last,
                     got.red, got.green, got.blue, got.row, got.col, got.last);
          end
        end
      end

      if (pixel.valid && pixel.ready)
        take_pixel({pixel.in_blue, pixel.in_green, pixel.in_red});
    end
    errors      <= error_total;
    outstanding <= expected_pixels.size();
  end

endmodule

/* tb/sv/window_3x3_blur_laplace_filter_top_test.sv */
// top of the window filter testbench: clock, reset, stimulus, register writes and verdict
`timescale 1ns / 1ps

module window_3x3_blur_laplace_filter_top_test;
  import w3f_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 4;
  // settle time that covers the path from the completing transfer to its result
  localparam int SETTLE_CYCLES = 8;
  // long receiver hold-off, far beyond the block's internal queue
  localparam int LONG_HOLD    = 120;
  localparam int RANDOM_ITEMS = 360;  // per idling phase
  // watchdog limit for the whole run, in nanoseconds
  localparam longint TIMEOUT_NS = 64'd10_000_000;

  // ways of disturbing an image in the middle of its raster
  typedef enum int {
    MID_HEIGHT = 0,  // new height while rows are in flight
    MID_WIDTH  = 1,  // rows no wider than before from the next pixel on
    MID_PAUSE  = 2,  // sender stops until every result is back, mode may change
    MID_NONE   = 3
  } mid_change_t;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 72;
  int unsigned hold_kicks    = 0;

  w3f_pix_if                  pixel ();
  w3f_res_if #(.COL_W(COL_W)) result ();

  window_3x3_blur_laplace_filter_top #(.MAX_WIDTH(MAX_WIDTH)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicts every filtered pixel and compares the result channel
  w3f_result_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .result      (result),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver: random back-pressure, plus a long hold-off whenever the stimulus asks
  // for one; the hold is counted here so the sender keeps offering pixels meanwhile
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  initial result.ready = 1'b0;
  always @(posedge clk) begin
    if (hold_kicks != hold_seen) begin
      hold_seen = hold_kicks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned eff_dim(int unsigned raw, int unsigned hi);
    return (raw < MIN_DIM) ? MIN_DIM : (raw > hi) ? hi : raw;
  endfunction

  // biased toward the channel extremes; smooth images stay near a base level so
  // the laplace kernel stays within 80 of zero and never clamps high
  function automatic logic [7:0] pick_level(logic smooth, int unsigned base);
    if (smooth) return 8'(base + $urandom_range(20));
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one register access: setup phase, access phase, then an idle phase so the
  // next access never reassigns psel in the same step
  task automatic apb_access(logic write, reg_index_t idx, logic [DATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write with random junk above the field, then read it back for the checker
  task automatic write_field(reg_index_t idx, int unsigned value);
    logic [DATA_W-1:0] junk;
    logic [DATA_W-1:0] word;
    junk = $urandom;
    case (idx)
      REG_IMAGE_WIDTH:  word = {junk[DATA_W-1:WIDTH_REG_W], value[WIDTH_REG_W-1:0]};
      REG_IMAGE_HEIGHT: word = {junk[DATA_W-1:HEIGHT_W], value[HEIGHT_W-1:0]};
      default:          word = {junk[DATA_W-1:1], value[0]};
    endcase
    apb_access(1'b1, idx, word);
    apb_access(1'b0, idx, '0);
  endtask

  task automatic program_image(int unsigned raw_w, int unsigned raw_h, logic mode);
    write_field(REG_IMAGE_WIDTH, raw_w);
    write_field(REG_IMAGE_HEIGHT, raw_h);
    write_field(REG_FILTER_MODE, mode);
  endtask

  // offer one pixel and hold it until its transfer; valid stays high into the next
  // pixel unless the random gap drops it
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel.valid <= 1'b0;
      @(posedge clk);
    end
    pixel.valid    <= 1'b1;
    pixel.in_red   <= r;
    pixel.in_green <= g;
    pixel.in_blue  <= b;
    do @(posedge clk); while (!pixel.ready);
  endtask

  task automatic send_pixels(int unsigned n, logic smooth, int unsigned base);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(pick_level(smooth, base), pick_level(smooth, base), pick_level(smooth, base));
  endtask

  // stop offering and wait for every expected result, then let the pipeline settle
  // since border pixels may still be in flight with nothing expected
  task automatic drain();
    pixel.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // small random images, some with a register change or a pause mid-raster
  task automatic random_images(int unsigned budget);
    int unsigned sent;
    int unsigned raw_w;
    int unsigned raw_h;
    int unsigned w;
    int unsigned h;
    int unsigned pos;
    int unsigned row;
    int unsigned col;
    int unsigned tail;
    int unsigned new_raw;
    int unsigned new_eff;
    int unsigned base;
    int unsigned draw;
    logic        smooth;
    mid_change_t change;
    sent = 0;
    while (sent < budget) begin
      raw_w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(12, 3);
      raw_h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
      program_image(raw_w, raw_h, 1'($urandom_range(1)));
      w      = eff_dim(raw_w, MAX_WIDTH);
      h      = eff_dim(raw_h, MAX_HEIGHT);
      smooth = 1'($urandom_range(1));
      base   = $urandom_range(235);
      pos    = $urandom_range(w * h - 1);
      row    = pos / w;
      col    = pos % w;
      draw   = $urandom_range(5);
      change = (draw > MID_NONE) ? MID_NONE : mid_change_t'(draw);
      case (change)
        MID_HEIGHT: begin
          // rest of the current row, then rows up to the new height if it lies ahead
          send_pixels(pos, smooth, base);
          drain();
          new_raw = $urandom_range(10);
          new_eff = eff_dim(new_raw, MAX_HEIGHT);
          write_field(REG_IMAGE_HEIGHT, new_raw);
          tail = (w - col) + ((row + 1 >= new_eff) ? 0 : (new_eff - row - 1) * w);
          send_pixels(tail, smooth, base);
          sent += pos + tail;
        end
        MID_WIDTH: begin
          // never wider, so every line store column read was written this image
          send_pixels(pos, smooth, base);
          drain();
          new_raw = $urandom_range(w);
          new_eff = eff_dim(new_raw, MAX_WIDTH);
          write_field(REG_IMAGE_WIDTH, new_raw);
          tail = ((col + 1 >= new_eff) ? 1 : new_eff - col) + (h - row - 1) * new_eff;
          send_pixels(tail, smooth, base);
          sent += pos + tail;
        end
        MID_PAUSE: begin
          send_pixels(pos, smooth, base);
          drain();
          write_field(REG_FILTER_MODE, $urandom_range(1));
          send_pixels(w * h - pos, smooth, base);
          sent += w * h;
        end
        default: begin
          send_pixels(w * h, smooth, base);
          sent += w * h;
        end
      endcase
      drain();
    end
  endtask

  initial begin
    pixel.valid    <= 1'b0;
    pixel.in_red   <= '0;
    pixel.in_green <= '0;
    pixel.in_blue  <= '0;
    send_idle_pct  <= 33;
    recv_idle_pct  <= 72;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of the registers
    apb_access(1'b0, REG_IMAGE_WIDTH, '0);
    apb_access(1'b0, REG_IMAGE_HEIGHT, '0);
    apb_access(1'b0, REG_FILTER_MODE, '0);

    // smallest image, box average of full-scale pixels must stay at full scale
    program_image(3, 3, FILTER_BOX);
    repeat (9) send_pixel(8'hFF, 8'hFF, 8'hFF);
    drain();

    // laplace clamping: red clamps high, green clamps low, blue lands just inside
    program_image(3, 3, FILTER_LAPLACE);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_pixel(8'hFF, 8'h00, 8'h40);
      else        send_pixel(8'h00, 8'hFF, 8'h01);
    end
    drain();

    // width and height below the minimum act as three; box sum truncates
    program_image(0, 1, FILTER_BOX);
    for (int i = 0; i < 9; i++)
      send_pixel(8'(i * 28), 8'(255 - i * 28), (i == 8) ? 8'hFF : 8'h00);
    drain();

    // phase one: slow receiver, with one long hold-off
    hold_kicks <= hold_kicks + 1;
    random_images(RANDOM_ITEMS);

    // phase two: slow sender
    send_idle_pct <= 72;
    recv_idle_pct <= 33;
    @(posedge clk);
    random_images(RANDOM_ITEMS);

    // phase three: no idling, hold-off while the sender streams so the input stalls
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_kicks    <= hold_kicks + 1;
    @(posedge clk);
    random_images(RANDOM_ITEMS);

    // size registers above the limits act as the limits; only the start of the
    // first row goes out, so no result is due
    program_image(2047, 8191, 1'($urandom_range(1)));
    send_pixels(48, 1'b0, 0);
    drain();

    if (errors == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
